// ===== design/double_ended_stack_allocator_unit_assert.svh =====
// Assertion macros shared by the allocator checker.
// No dependencies; included by design/desa_checker.sv.
`ifndef DOUBLE_ENDED_STACK_ALLOCATOR_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_STACK_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define DESA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define DESA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/desa_pkg.sv =====
// Shared types, widths and codes of the double-ended stack allocator.
// No dependencies; imported by every allocator module.
package desa_pkg;

    // Build-time sizing
    localparam int ADDR_WIDTH = 32;
    localparam int SIZE_WIDTH = 24;

    // Field widths
    localparam int BASE_W  = 32;
    localparam int SIZE_W  = 25;
    localparam int DALIGN_W = 17;
    localparam int ALIGN_W = 18;
    localparam int CNT_W   = 25;
    localparam int PTR_W   = 34;   // base + size + alignment slack + amount
    localparam int IDX_W   = 2;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 136;

    localparam logic [63:0] ADDR_MASK  = (ADDR_WIDTH >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                         : ((64'd1 << ADDR_WIDTH) - 64'd1);
    localparam logic [63:0] SIZE_LIMIT = 64'd1 << SIZE_WIDTH;

    // Operation codes
    localparam logic [1:0] OP_ALLOC     = 2'd0;
    localparam logic [1:0] OP_FREE_TAIL = 2'd1;
    localparam logic [1:0] OP_FREE_ALL  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_AMT  = 2'd1;
    localparam logic [1:0] ST_BAD_ALIGN = 2'd2;
    localparam logic [1:0] ST_NO_ROOM   = 2'd3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_HEAP_BASE     = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEAP_SIZE     = 2'd1;
    localparam logic [IDX_W-1:0] REG_DEFAULT_ALIGN = 2'd2;

    localparam logic [DALIGN_W-1:0] DEFAULT_ALIGN_RST = 17'd8;

    typedef struct packed {
        logic [BASE_W-1:0]   heap_base;
        logic [SIZE_W-1:0]   heap_size;
        logic [DALIGN_W-1:0] default_align;
    } cfg_t;

    typedef struct packed {
        logic [1:0]               op;
        logic [SIZE_W-1:0]        amount;
        logic signed [ALIGN_W-1:0] align;
    } req_t;

    typedef struct packed {
        logic [31:0]      address;
        logic [1:0]       status;
        logic [CNT_W-1:0] used_bytes;
        logic [CNT_W-1:0] free_bytes;
        logic [CNT_W-1:0] live_count;
        logic [CNT_W-1:0] back_count;
    } rsp_t;

endpackage

// ===== design/desa_cfg_regs.sv =====
// Configuration registers of the allocator: heap base, heap size, default alignment.
// Depends on desa_pkg.
module desa_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [desa_pkg::IDX_W-1:0] cfg_index,
    input  logic [31:0]               cfg_data,
    output desa_pkg::cfg_t            cfg
);
    import desa_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode one register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEAP_BASE:     cfg_next.heap_base     = cfg_data;
                REG_HEAP_SIZE:     cfg_next.heap_size     = cfg_data[SIZE_W-1:0];
                REG_DEFAULT_ALIGN: cfg_next.default_align = cfg_data[DALIGN_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heap_base     <= '0;
            cfg_reg.heap_size     <= '0;
            cfg_reg.default_align <= DEFAULT_ALIGN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/desa_engine.sv =====
// Allocation datapath and usage state: one request per fire, result from next state.
// Depends on desa_pkg.
module desa_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  desa_pkg::cfg_t cfg,
    input  logic           fire,
    input  desa_pkg::req_t req,
    output desa_pkg::rsp_t rsp
);
    import desa_pkg::*;

    logic [CNT_W-1:0] front_used_reg, front_used_next;
    logic [CNT_W-1:0] back_used_reg,  back_used_next;
    logic [CNT_W-1:0] total_allocs_reg, total_allocs_next;
    logic [CNT_W-1:0] back_allocs_reg,  back_allocs_next;

    logic [SIZE_W-1:0]  eff_size;
    logic [PTR_W-1:0]   base_ext, front, end_ptr, back, amt, mask;
    logic [PTR_W-1:0]   p_front, front_top, p_back, gap;
    logic [ALIGN_W-1:0] align_u, a, a_m1;
    logic               back_side, a_ok, end_short;
    logic [31:0]        addr;
    logic [1:0]         status;
    logic [CNT_W:0]     used;

    // Region geometry and alignment decode
    always_comb
    begin
        eff_size  = ({39'd0, cfg.heap_size} > SIZE_LIMIT) ? SIZE_LIMIT[SIZE_W-1:0]
                                                         : cfg.heap_size;
        base_ext  = {{(PTR_W-BASE_W){1'b0}}, cfg.heap_base};
        front     = base_ext + PTR_W'(front_used_reg);
        end_ptr   = base_ext + PTR_W'(eff_size);
        end_short = PTR_W'(back_used_reg) > end_ptr;
        back      = end_ptr - PTR_W'(back_used_reg);
        amt       = PTR_W'(req.amount);

        align_u = req.align;
        if (align_u == '0)
        begin
            a         = ALIGN_W'(cfg.default_align);
            back_side = 1'b0;
        end
        else if (align_u[ALIGN_W-1])
        begin
            a         = ALIGN_W'(0) - align_u;
            back_side = 1'b1;
        end
        else
        begin
            a         = align_u;
            back_side = 1'b0;
        end
        a_m1 = a - ALIGN_W'(1);
        a_ok = (a != '0) && ((a & a_m1) == '0);
        mask = PTR_W'(a_m1);

        // Front: round up then bump; back: drop by amount then round down
        p_front   = (front + mask) & ~mask;
        front_top = p_front + amt;
        gap       = back - front;
        p_back    = (back - amt) & ~mask;
    end

    // Request outcome and next state
    always_comb
    begin
        front_used_next   = front_used_reg;
        back_used_next    = back_used_reg;
        total_allocs_next = total_allocs_reg;
        back_allocs_next  = back_allocs_reg;
        addr              = '0;
        status            = ST_OK;

        unique case (req.op)
            OP_ALLOC:
            begin
                priority if (req.amount == '0)
                    status = ST_ZERO_AMT;
                else if (!a_ok)
                    status = ST_BAD_ALIGN;
                else if (end_short)
                    status = ST_NO_ROOM;
                else if (!back_side)
                begin
                    if (front_top > back)
                        status = ST_NO_ROOM;
                    else
                    begin
                        front_used_next   = CNT_W'(front_top - base_ext);
                        total_allocs_next = total_allocs_reg + CNT_W'(1);
                        addr              = p_front[31:0] & ADDR_MASK[31:0];
                    end
                end
                else
                begin
                    if ((back < front) || (gap < amt) || (p_back < front))
                        status = ST_NO_ROOM;
                    else
                    begin
                        back_used_next    = CNT_W'(end_ptr - p_back);
                        back_allocs_next  = back_allocs_reg + CNT_W'(1);
                        total_allocs_next = total_allocs_reg + CNT_W'(1);
                        addr              = p_back[31:0] & ADDR_MASK[31:0];
                    end
                end
            end
            OP_FREE_TAIL:
            begin
                back_used_next    = '0;
                total_allocs_next = total_allocs_reg - back_allocs_reg;
                back_allocs_next  = '0;
            end
            OP_FREE_ALL:
            begin
                front_used_next   = '0;
                back_used_next    = '0;
                total_allocs_next = '0;
                back_allocs_next  = '0;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // Result fields reflect the state after this request
    always_comb
    begin
        used            = (CNT_W+1)'(front_used_next) + (CNT_W+1)'(back_used_next);
        rsp.address     = addr;
        rsp.status      = status;
        rsp.used_bytes  = used[CNT_W-1:0];
        rsp.free_bytes  = ((CNT_W+1)'(eff_size) > used)
                          ? CNT_W'((CNT_W+1)'(eff_size) - used) : '0;
        rsp.live_count  = total_allocs_next;
        rsp.back_count  = back_allocs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_used_reg   <= '0;
            back_used_reg    <= '0;
            total_allocs_reg <= '0;
            back_allocs_reg  <= '0;
        end
        else if (fire)
        begin
            front_used_reg   <= front_used_next;
            back_used_reg    <= back_used_next;
            total_allocs_reg <= total_allocs_next;
            back_allocs_reg  <= back_allocs_next;
        end
    end

endmodule

// ===== design/double_ended_stack_allocator_unit.sv =====
// Double-ended stack allocator, top level: stream ports, request and result registers.
// Depends on desa_pkg, desa_cfg_regs, desa_engine.
//
// One request (allocate, free back region, free all) enters a request register,
// passes the combinational allocation datapath and lands in a result register;
// each request gives exactly one result. A new request is taken every cycle
// while the result side is not stalled, since the usage state is updated in the
// same cycle that the result register loads. Front allocations round the front
// pointer up and bump it; a negative alignment takes the block from the back.
// Registers may be written only while no request is in flight.
module double_ended_stack_allocator_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write port
    input  logic                           cfg_we,
    input  logic [desa_pkg::IDX_W-1:0]      cfg_index,
    input  logic [31:0]                    cfg_data,
    // Request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [desa_pkg::IN_DATA_W-1:0]  s_tdata,   // op[1:0], amount[26:2], align[44:27]
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [desa_pkg::OUT_DATA_W-1:0] m_tdata    // address[31:0], status[33:32],
                                                      // used_bytes[58:34], free_bytes[83:59],
                                                      // live_count[108:84], back_count[133:109]
);
    import desa_pkg::*;

    cfg_t cfg;
    req_t in_req_reg, in_req_next;
    rsp_t out_rsp_reg, rsp;
    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_free, fire, s_accept;

    desa_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    desa_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (fire),
        .req   (in_req_reg),
        .rsp   (rsp)
    );

    // Flow control between request and result registers
    always_comb
    begin
        out_free = !out_valid_reg || m_tready;
        fire     = in_valid_reg && out_free;
        s_tready = !in_valid_reg || out_free;
        s_accept = s_tvalid && s_tready;

        in_valid_next  = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

        in_req_next.op     = s_tdata[1:0];
        in_req_next.amount = s_tdata[26:2];
        in_req_next.align  = s_tdata[44:27];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
            in_req_reg <= in_req_next;
        if (fire)
            out_rsp_reg <= rsp;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_rsp_reg.back_count,
                       out_rsp_reg.live_count,
                       out_rsp_reg.free_bytes,
                       out_rsp_reg.used_bytes,
                       out_rsp_reg.status,
                       out_rsp_reg.address};

endmodule

// ===== design/desa_checker.sv =====
// Port-level checker for the double-ended stack allocator, bound to the top level.
// Depends on desa_pkg and double_ended_stack_allocator_unit_assert.svh.
`include "double_ended_stack_allocator_unit_assert.svh"

module desa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_we,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [desa_pkg::OUT_DATA_W-1:0] m_tdata
);
    import desa_pkg::*;

    // A stalled result keeps its payload
    `DESA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // A failed allocation never reports an address
    `DESA_ASSERT_NOW(a_fail_no_addr, m_tvalid && (m_tdata[33:32] != ST_OK), m_tdata[31:0] == 32'd0, "failed request carries an address")

    // Back allocations are a subset of the live ones
    `DESA_ASSERT_NOW(a_back_le_live, m_tvalid, m_tdata[133:109] <= m_tdata[108:84], "back count exceeds live count")

    // With the result side empty, the request side must take new requests
    `DESA_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "request stalled with empty result register")

    // Registers are only written with no result waiting
    `DESA_ASSERT_NOW(a_cfg_idle, cfg_we, !m_tvalid, "register written with a result pending")

endmodule

bind double_ended_stack_allocator_unit desa_checker u_desa_checker (.*);

// ===== tb/double_ended_stack_allocator_unit_test.sv =====
// Self-checking testbench for the double-ended stack allocator: directed and random requests.
// An in-bench allocator predictor checks every result. Depends on desa_pkg and the unit RTL.
module double_ended_stack_allocator_unit_test;
    import desa_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         DRAIN_CYCLES = 4;
    localparam int         CYCLE_LIMIT  = 200000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [IDX_W-1:0]      cfg_index = '0;
    logic [31:0]           cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Predictor copy of the region registers and usage state
    logic [BASE_W-1:0]   region_base;
    logic [SIZE_W-1:0]   region_size;
    logic [DALIGN_W-1:0] fallback_align;
    logic [63:0]         front_taken;
    logic [63:0]         back_taken;
    logic [CNT_W-1:0]    live_blocks;
    logic [CNT_W-1:0]    tail_blocks;

    rsp_t pending_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int failures = 0;
    int cycle_count = 0;
    int requests_sent = 0;
    int grants = 0;
    int refusals = 0;
    int frees = 0;
    int settings_used = 0;

    double_ended_stack_allocator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[double_ended_stack_allocator_unit] ERROR");
            $finish;
        end
    end

    // Result side back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Work out the result of one accepted request and update the usage state
    function automatic rsp_t predict_result(input logic [1:0] op,
                                            input logic [SIZE_W-1:0] amount,
                                            input logic [ALIGN_W-1:0] align);
        rsp_t               r;
        logic [ALIGN_W-1:0] neg_align;
        logic [63:0]        mag, span, region_end, front, back, spot, need, used, room;
        logic               from_back;
        r = '0;
        spot = '0;
        span = (64'(region_size) > SIZE_LIMIT) ? SIZE_LIMIT : 64'(region_size);
        region_end = 64'(region_base) + span;
        front = 64'(region_base) + front_taken;
        need = 64'(amount);
        neg_align = -align;
        from_back = align[ALIGN_W-1];
        if (align == '0)
            mag = 64'(fallback_align);
        else if (from_back)
            mag = 64'(neg_align);
        else
            mag = 64'(align);

        case (op)
            OP_ALLOC:
            begin
                r.status = ST_OK;
                if (need == 0)
                    r.status = ST_ZERO_AMT;
                else if (mag == 0 || (mag & (mag - 1)) != 0)
                    r.status = ST_BAD_ALIGN;
                else if (back_taken > region_end)
                    r.status = ST_NO_ROOM;
                else
                begin
                    back = region_end - back_taken;
                    if (!from_back)
                    begin
                        // round the front up, then bump it
                        spot = (front + mag - 1) & ~(mag - 1);
                        if (spot + need > back)
                            r.status = ST_NO_ROOM;
                        else
                            front_taken = spot + need - 64'(region_base);
                    end
                    else if (back < front || back - front < need)
                        r.status = ST_NO_ROOM;
                    else
                    begin
                        // carve from the back, rounded down
                        spot = (back - need) & ~(mag - 1);
                        if (spot < front)
                            r.status = ST_NO_ROOM;
                        else
                        begin
                            back_taken = region_end - spot;
                            tail_blocks = tail_blocks + CNT_W'(1);
                        end
                    end
                end
                if (r.status == ST_OK)
                begin
                    live_blocks = live_blocks + CNT_W'(1);
                    r.address = spot[31:0] & ADDR_MASK[31:0];
                end
            end
            OP_FREE_TAIL:
            begin
                back_taken = '0;
                live_blocks = live_blocks - tail_blocks;
                tail_blocks = '0;
            end
            OP_FREE_ALL:
            begin
                front_taken = '0;
                back_taken = '0;
                live_blocks = '0;
                tail_blocks = '0;
            end
            default: ;
        endcase

        used = front_taken + back_taken;
        room = (span > used) ? span - used : 64'd0;
        r.used_bytes = used[CNT_W-1:0];
        r.free_bytes = room[CNT_W-1:0];
        r.live_count = live_blocks;
        r.back_count = tail_blocks;
        return r;
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_HEAP_BASE:     region_base = value;
            REG_HEAP_SIZE:     region_size = value[SIZE_W-1:0];
            REG_DEFAULT_ALIGN: fallback_align = value[DALIGN_W-1:0];
            default: ;
        endcase
    endtask

    // Only called with no request in flight
    task automatic configure(input logic [31:0] base, input logic [SIZE_W-1:0] size,
                             input logic [DALIGN_W-1:0] dalign);
        write_reg(REG_HEAP_BASE, base);
        write_reg(REG_HEAP_SIZE, 32'(size));
        write_reg(REG_DEFAULT_ALIGN, 32'(dalign));
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Present one request, wait for the handshake, record the expected result
    task automatic send_request(input logic [1:0] op, input logic [SIZE_W-1:0] amount,
                                input logic [ALIGN_W-1:0] align);
        rsp_t want;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, align, amount, op};
        do @(posedge clk); while (!s_tready);
        want = predict_result(op, amount, align);
        pending_results.push_back(want);
        requests_sent++;
        if (op == OP_ALLOC)
        begin
            if (want.status == ST_OK)
                grants++;
            else
                refusals++;
        end
        else
            frees++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: %0h", m_tdata);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("address", want.address, m_tdata[31:0]);
                check_field("status", 32'(want.status), 32'(m_tdata[33:32]));
                check_field("used_bytes", 32'(want.used_bytes), 32'(m_tdata[58:34]));
                check_field("free_bytes", 32'(want.free_bytes), 32'(m_tdata[83:59]));
                check_field("live_count", 32'(want.live_count), 32'(m_tdata[108:84]));
                check_field("back_count", 32'(want.back_count), 32'(m_tdata[133:109]));
            end
        end
    end

    // Front allocations with default and explicit alignment
    task automatic test_front_allocations();
        configure(32'h0000_1000, 25'h1000, 17'd8);
        send_request(OP_ALLOC, 25'd16, 18'd0);
        send_request(OP_ALLOC, 25'd5, 18'd1);
        send_request(OP_ALLOC, 25'd100, 18'd64);
        send_request(OP_ALLOC, 25'd7, 18'd65536);
        wait_for_results();
    endtask

    // Back allocations, free of the back region, unused op code
    task automatic test_back_allocations();
        send_request(OP_ALLOC, 25'd32, -18'sd16);
        send_request(OP_ALLOC, 25'd1, -18'sd1);
        send_request(OP_ALLOC, 25'd3, 18'h20000);
        send_request(OP_FREE_TAIL, 25'd0, 18'd0);
        send_request(OP_UNUSED, 25'h1FFFFFF, 18'h3FFFF);
        wait_for_results();
    endtask

    // Zero amount, bad alignment, request too big, free everything
    task automatic test_rejections();
        send_request(OP_ALLOC, 25'd0, 18'd4);
        send_request(OP_ALLOC, 25'd1, 18'd3);
        send_request(OP_ALLOC, 25'd1, 18'h1FFFF);
        send_request(OP_ALLOC, 25'h1FFFFFF, 18'd1);
        send_request(OP_FREE_ALL, 25'd0, 18'd0);
        wait_for_results();
    endtask

    // Top of the address space, oversized region, widest default alignment
    task automatic test_region_extremes();
        configure(32'hFFFF_FFFF, 25'h1FFFFFF, 17'd65536);
        send_request(OP_ALLOC, 25'd1, 18'd0);
        send_request(OP_ALLOC, 25'h1000000, -18'sd1);
        send_request(OP_ALLOC, 25'd100, -18'sd1);
        wait_for_results();
    endtask

    // Shrink the region under live blocks, zero default alignment, exact fill
    task automatic test_reconfigure_live();
        configure(32'h0, 25'd8, 17'd0);
        send_request(OP_ALLOC, 25'd1, 18'd0);
        send_request(OP_ALLOC, 25'd1, 18'd1);
        wait_for_results();
        // back pointer now sits below the front pointer
        configure(32'h0, 25'd0, 17'd1);
        send_request(OP_ALLOC, 25'd1, 18'd0);
        send_request(OP_ALLOC, 25'd1, -18'sd1);
        send_request(OP_FREE_ALL, 25'd0, 18'd0);
        wait_for_results();
        configure(32'h0, 25'd64, 17'd4);
        send_request(OP_ALLOC, 25'd64, 18'd0);
        send_request(OP_ALLOC, 25'd1, -18'sd1);
        send_request(OP_FREE_ALL, 25'd0, 18'd0);
        wait_for_results();
    endtask

    // Mostly well-formed allocate/free traffic over random regions
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        logic [31:0]         base;
        logic [SIZE_W-1:0]   size;
        logic [DALIGN_W-1:0] dalign;
        logic [1:0]          op;
        logic [SIZE_W-1:0]   amount;
        logic [ALIGN_W-1:0]  align;
        int                  pick;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (4)
        begin
            pick = $urandom_range(99);
            base = (pick < 20) ? 32'h0 :
                   (pick < 30) ? 32'hFFFF_F000 + $urandom_range(0, 4095) : $urandom;
            pick = $urandom_range(99);
            if (pick < 75)
                size = SIZE_W'($urandom_range(256, 8192));
            else if (pick < 85)
                size = SIZE_W'($urandom_range(0, 255));
            else if (pick < 95)
                size = SIZE_W'($urandom_range(8193, 1 << 20));
            else
                size = SIZE_W'($urandom_range(0, 32'h1FFFFFF));
            if ($urandom_range(99) < 85)
                dalign = 17'd1 << $urandom_range(0, 16);
            else
                dalign = DALIGN_W'($urandom_range(0, 32'h1FFFF));
            configure(base, size, dalign);

            repeat (32)
            begin
                pick = $urandom_range(99);
                op = (pick < 85) ? OP_ALLOC : (pick < 91) ? OP_FREE_TAIL :
                     (pick < 96) ? OP_FREE_ALL : OP_UNUSED;
                pick = $urandom_range(99);
                if (pick < 60)
                    amount = SIZE_W'($urandom_range(1, 64));
                else if (pick < 80)
                    amount = SIZE_W'($urandom_range(1, 1024));
                else if (pick < 92)
                    amount = SIZE_W'($urandom_range(0, 32'h1FFFFFF));
                else
                    amount = '0;
                pick = $urandom_range(99);
                if (pick < 25)
                    align = '0;
                else if (pick < 90)
                begin
                    align = 18'd1 << $urandom_range(0, 10);
                    if (pick >= 57)
                        align = -align;
                end
                else
                    align = ALIGN_W'($urandom_range(0, 32'h3FFFF));
                send_request(op, amount, align);
            end
            wait_for_results();
        end
    endtask

    initial
    begin
        region_base = '0;
        region_size = '0;
        fallback_align = DEFAULT_ALIGN_RST;
        front_taken = '0;
        back_taken = '0;
        live_blocks = '0;
        tail_blocks = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_front_allocations();
        test_back_allocations();
        test_rejections();
        test_region_extremes();
        test_reconfigure_live();

        test_random_traffic(0, 0);
        test_random_traffic(54, 0);
        test_random_traffic(0, 54);
        test_random_traffic(22, 22);

        $display("Covered %0d requests: %0d granted, %0d refused, %0d free or unused ops,",
                 requests_sent, grants, refusals, frees);
        $display("over %0d region settings with free-running, gapped and stalled handshakes.",
                 settings_used);
        if (failures == 0)
            $display("[double_ended_stack_allocator_unit] OK");
        else
            $display("[double_ended_stack_allocator_unit] ERROR");
        $finish;
    end

endmodule
